// File: rtl/core/imusd_pkg.sv
// imusd_pkg: shared types and constants for the imu stillness detector
// used by every module under rtl/core, no dependencies of its own
package imusd_pkg;

   localparam int AxisW   = 16;              // raw sensor axis and bias width
   localparam int TimeW   = 63;              // sample timestamp width
   localparam int SqW     = 32;              // one squared axis term
   localparam int MagW    = 34;              // sum of three squares and bounds
   localparam int HoldUsW = 26;              // hold_ms * 1000 fits here
   localparam int CsrIdxW = 3;
   localparam int ReqDataW = 160;            // 6*16 + 63, padded to bytes
   localparam int RspDataW = 8;

   // configuration register indexes
   typedef enum logic [CsrIdxW-1:0] {
      RegOneG    = 3'd0,
      RegAccTol  = 3'd1,
      RegGyroLim = 3'd2,
      RegHold    = 3'd3,
      RegBiasX   = 3'd4,
      RegBiasY   = 3'd5,
      RegBiasZ   = 3'd6
   } csr_reg_type;

   // gyro bias per axis, signed counts
   typedef struct packed {
      logic [AxisW-1:0] x;
      logic [AxisW-1:0] y;
      logic [AxisW-1:0] z;
   } bias_type;

   // squared thresholds derived from the configuration
   typedef struct packed {
      logic [MagW-1:0]    upper_sq;
      logic               lower_on;   // one g minus tolerance is not negative
      logic [MagW-1:0]    lower_sq;
      logic [MagW-1:0]    glim_sq;
      logic [HoldUsW-1:0] hold_us;
   } bounds_type;

   // squared terms of one sample, held between the two stages
   typedef struct packed {
      logic [SqW-1:0]   asq_x;
      logic [SqW-1:0]   asq_y;
      logic [SqW-1:0]   asq_z;
      logic [SqW-1:0]   gsq_x;
      logic [SqW-1:0]   gsq_y;
      logic [SqW-1:0]   gsq_z;
      logic [TimeW-1:0] time_us;
      logic             sample_ok;
   } sq_stage_type;

endpackage

// File: rtl/core/imusd_csr.sv
// imusd_csr: configuration registers and the squared bounds derived from them
// depends on imusd_pkg
module imusd_csr
   import imusd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [AxisW-1:0]     csr_wdata,
   output bias_type             bias,
   output bounds_type           bounds
);

   logic [14:0]      one_g_ff, one_g_in;
   logic [15:0]      acc_tol_ff, acc_tol_in;
   logic [15:0]      gyro_lim_ff, gyro_lim_in;
   logic [15:0]      hold_ms_ff, hold_ms_in;
   bias_type         bias_ff, bias_in;
   bounds_type       bounds_ff, bounds_in;
   logic [16:0]      upper;
   logic [15:0]      lower_diff;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      one_g_in    = one_g_ff;
      acc_tol_in  = acc_tol_ff;
      gyro_lim_in = gyro_lim_ff;
      hold_ms_in  = hold_ms_ff;
      bias_in     = bias_ff;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            RegOneG:    one_g_in    = csr_wdata[14:0];
            RegAccTol:  acc_tol_in  = csr_wdata;
            RegGyroLim: gyro_lim_in = csr_wdata;
            RegHold:    hold_ms_in  = csr_wdata;
            RegBiasX:   bias_in.x   = csr_wdata;
            RegBiasY:   bias_in.y   = csr_wdata;
            RegBiasZ:   bias_in.z   = csr_wdata;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_g_ff    <= 15'd4096;
         acc_tol_ff  <= 16'd410;
         gyro_lim_ff <= 16'd66;
         hold_ms_ff  <= 16'd1000;
         bias_ff     <= '0;
      end else begin
         one_g_ff    <= one_g_in;
         acc_tol_ff  <= acc_tol_in;
         gyro_lim_ff <= gyro_lim_in;
         hold_ms_ff  <= hold_ms_in;
         bias_ff     <= bias_in;
      end
   end

   // squared bounds, one multiplier each, registered
   always_comb begin
      upper              = {2'b00, one_g_ff} + {1'b0, acc_tol_ff};
      lower_diff         = {1'b0, one_g_ff} - acc_tol_ff;
      bounds_in.upper_sq = MagW'(upper * upper);
      bounds_in.lower_on = ({1'b0, one_g_ff} >= acc_tol_ff);
      bounds_in.lower_sq = MagW'(lower_diff[14:0] * lower_diff[14:0]);
      bounds_in.glim_sq  = MagW'(gyro_lim_ff * gyro_lim_ff);
      bounds_in.hold_us  = HoldUsW'(hold_ms_ff * 10'd1000);
   end

   always_ff @(posedge clock) begin
      bounds_ff <= bounds_in;
   end

   assign bias   = bias_ff;
   assign bounds = bounds_ff;

endmodule

// File: rtl/core/imusd_square_stage.sv
// imusd_square_stage: first pipeline stage, squares of accel and bias-corrected gyro
// depends on imusd_pkg
module imusd_square_stage
   import imusd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [ReqDataW-1:0] in_data,
   input  logic                in_ok,
   input  bias_type            bias,
   output logic                valid,
   output sq_stage_type        sq
);

   logic                valid_ff, valid_in;
   sq_stage_type        sq_ff, sq_in;
   logic signed [15:0]  ax, ay, az;
   logic signed [16:0]  gx, gy, gz;
   logic signed [31:0]  apx, apy, apz;
   logic signed [33:0]  gpx, gpy, gpz;

   // signed squares, each one multiplier deep
   always_comb begin
      ax  = signed'(in_data[15:0]);
      ay  = signed'(in_data[31:16]);
      az  = signed'(in_data[47:32]);
      gx  = signed'({in_data[63], in_data[63:48]}) - signed'({bias.x[15], bias.x});
      gy  = signed'({in_data[79], in_data[79:64]}) - signed'({bias.y[15], bias.y});
      gz  = signed'({in_data[95], in_data[95:80]}) - signed'({bias.z[15], bias.z});
      apx = ax * ax;
      apy = ay * ay;
      apz = az * az;
      gpx = gx * gx;
      gpy = gy * gy;
      gpz = gz * gz;
      sq_in.asq_x     = unsigned'(apx);
      sq_in.asq_y     = unsigned'(apy);
      sq_in.asq_z     = unsigned'(apz);
      sq_in.gsq_x     = gpx[31:0];
      sq_in.gsq_y     = gpy[31:0];
      sq_in.gsq_z     = gpz[31:0];
      sq_in.time_us   = in_data[158:96];
      sq_in.sample_ok = in_ok;
   end

   assign valid_in = advance ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff <= sq_in;
      end
   end

   assign valid = valid_ff;
   assign sq    = sq_ff;

endmodule

// File: rtl/core/imusd_decide_stage.sv
// imusd_decide_stage: threshold tests, still-run tracking and the result register
// depends on imusd_pkg
module imusd_decide_stage
   import imusd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  sq_stage_type  sq,
   input  bounds_type    bounds,
   output logic          out_valid,
   output logic          stationary,
   output logic          still_now
);

   logic              out_valid_ff, out_valid_in;
   logic              stationary_ff, stationary_in;
   logic              still_now_ff, still_now_in;
   logic              run_active_ff, run_active_in;
   logic [TimeW-1:0]  run_start_ff, run_start_in;
   logic [MagW-1:0]   amag, gmag;
   logic              acc_ok, gyro_ok, still;
   logic [TimeW-1:0]  start_eff, elapsed;
   logic              take;

   // magnitude tests against squared bounds
   always_comb begin
      amag = MagW'(sq.asq_x) + MagW'(sq.asq_y) + MagW'(sq.asq_z);
      gmag = MagW'(sq.gsq_x) + MagW'(sq.gsq_y) + MagW'(sq.gsq_z);
      acc_ok  = (amag < bounds.upper_sq) && (!bounds.lower_on || (amag > bounds.lower_sq));
      gyro_ok = (gmag < bounds.glim_sq);
      still   = sq.sample_ok && acc_ok && gyro_ok;
   end

   // elapsed time of the run, a new run starts at this sample
   always_comb begin
      start_eff = run_active_ff ? run_start_ff : sq.time_us;
      elapsed   = (sq.time_us >= start_eff) ? (sq.time_us - start_eff) : '0;
   end

   assign take = advance && in_valid;

   // run state, a failed read leaves it alone
   always_comb begin
      run_active_in = run_active_ff;
      run_start_in  = run_start_ff;
      if (take && sq.sample_ok) begin
         run_active_in = still;
         run_start_in  = still ? start_eff : '0;
      end
   end

   // result register
   always_comb begin
      out_valid_in  = advance ? in_valid : out_valid_ff;
      stationary_in = stationary_ff;
      still_now_in  = still_now_ff;
      if (advance) begin
         stationary_in = still && (elapsed >= TimeW'(bounds.hold_us));
         still_now_in  = still;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         run_active_ff <= 1'b0;
         run_start_ff  <= '0;
      end else begin
         out_valid_ff  <= out_valid_in;
         run_active_ff <= run_active_in;
         run_start_ff  <= run_start_in;
      end
   end

   always_ff @(posedge clock) begin
      stationary_ff <= stationary_in;
      still_now_ff  <= still_now_in;
   end

   assign out_valid  = out_valid_ff;
   assign stationary = stationary_ff;
   assign still_now  = still_now_ff;

   // stationary is only ever reported on a still sample
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (still_now_ff || !stationary_ff))
      else $error("stationary reported without still sample");

   // a failed read never touches the run state
   assert property (@(posedge clock) disable iff (reset)
      (take && !sq.sample_ok) |=> ($stable(run_active_ff) && $stable(run_start_ff)))
      else $error("failed read changed run state");

   // while the result waits, run state holds
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(run_active_ff) && $stable(stationary_ff)))
      else $error("state moved during output stall");

   // every still sample leaves the run active, also when none was active before
   assert property (@(posedge clock) disable iff (reset)
      (take && still) |=> run_active_ff)
      else $error("still sample did not leave a run active");

endmodule

// File: rtl/core/imu_stillness_detector_unit.sv
// imu_stillness_detector_unit: top level of the imu stillness detector
// depends on imusd_pkg, imusd_csr, imusd_square_stage, imusd_decide_stage

// Takes one 6-axis IMU sample per transaction and returns one transaction with
// still_now (accel magnitude within tolerance of one g and bias-corrected gyro
// magnitude below the limit) and stationary (still for at least hold_ms).
// The datapath is two registered stages: the six signed squares, then the sums,
// the compares and the still-run tracker that feeds the result register. A
// sample is accepted every cycle unless the result channel stalls; the squared
// bounds follow a write through the configuration and then the bounds register.
// Configuration writes are always accepted and belong only to idle periods.
module imu_stillness_detector_unit
   import imusd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // input sample channel
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // acc_x, acc_y, acc_z, rate_x, rate_y, rate_z,
                                            // time_us[62:0], one pad bit
   input  logic                req_tuser,   // sample_ok
   // result channel
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // stationary, still_now, six pad bits
   // configuration write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [AxisW-1:0]    csr_wdata
);

   bias_type      bias;
   bounds_type    bounds;
   sq_stage_type  sq;
   logic          sq_valid;
   logic          adv_sq, adv_out;
   logic          stationary, still_now;

   // pipeline advance: each stage moves when the one after it has room
   assign adv_out    = !rsp_tvalid || rsp_tready;
   assign adv_sq     = !sq_valid || adv_out;
   assign req_tready = adv_sq;

   imusd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .bias      (bias),
      .bounds    (bounds)
   );

   imusd_square_stage u_square (
      .clock    (clock),
      .reset    (reset),
      .advance  (adv_sq),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .in_ok    (req_tuser),
      .bias     (bias),
      .valid    (sq_valid),
      .sq       (sq)
   );

   imusd_decide_stage u_decide (
      .clock      (clock),
      .reset      (reset),
      .advance    (adv_out),
      .in_valid   (sq_valid),
      .sq         (sq),
      .bounds     (bounds),
      .out_valid  (rsp_tvalid),
      .stationary (stationary),
      .still_now  (still_now)
   );

   assign rsp_tdata = {6'b000000, still_now, stationary};

endmodule
